FILE: design/rvlw_pkg.sv
// Shared types, constants and helper functions of the ray voxel line walker.
package rvlw_pkg;

  localparam int COORD_BITS = 16;
  localparam int STEP_BITS  = 11;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int CMP_BITS   = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [STEP_BITS-1:0]       step_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    CMD_BEGIN   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_code_t;

  // One command beat as seen by the walker core
  typedef struct packed {
    cmd_code_t command;
    coord_t    start_x;
    coord_t    start_y;
    coord_t    start_z;
    coord_t    end_x;
    coord_t    end_y;
    coord_t    end_z;
  } cmd_t;

  // One result beat
  typedef struct packed {
    coord_t voxel_x;
    coord_t voxel_y;
    coord_t voxel_z;
    logic   point_valid;
    logic   final_point;
  } vox_t;

  // Absolute difference of two coordinates
  function automatic coord_t absdiff(input coord_t a, input coord_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Walk is over once the major-axis distance no longer exceeds the stride
  function automatic logic walk_done(input coord_t cur, input coord_t tgt, input step_t s);
    logic [CMP_BITS-1:0] sep;
    logic [CMP_BITS-1:0] lim;
    sep = CMP_BITS'(absdiff(cur, tgt));
    lim = CMP_BITS'(s);
    return sep <= lim;
  endfunction

  // Move one stride along an axis, wrapping at the coordinate width
  function automatic coord_t step_add(input coord_t v, input logic neg, input step_t s);
    coord_t sc;
    sc = COORD_BITS'(s);
    return neg ? (v - sc) : (v + sc);
  endfunction

endpackage

FILE: design/rvlw_ifs.sv
// Channel interfaces: command input, voxel result and configuration write.
interface rvlw_cmd_if import rvlw_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_code_t command;
  coord_t    start_x;
  coord_t    start_y;
  coord_t    start_z;
  coord_t    end_x;
  coord_t    end_y;
  coord_t    end_z;

  modport source (output valid, command, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, command, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface rvlw_vox_if import rvlw_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t voxel_x;
  coord_t voxel_y;
  coord_t voxel_z;
  logic   point_valid;
  logic   final_point;

  modport source (output valid, voxel_x, voxel_y, voxel_z, point_valid, final_point,
                  input ready);
  modport sink   (input valid, voxel_x, voxel_y, voxel_z, point_valid, final_point,
                  output ready);
endinterface

interface rvlw_cfg_if import rvlw_pkg::*; ();
  logic  valid;
  logic  ready;
  step_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/ray_voxel_line_walker_3d.sv
// Ray voxel line walker top level: a begin command loads a start and an end point in one
// beat and yields no result; each advance command yields one result beat, the next free
// voxel of the 3D Bresenham ray or a beat with point_valid low once the ray is finished.
// One command is taken every cycle while the buffer has space. An advance beat's voxel is
// registered into the buffer head, or the skid entry while the head waits; the absolute
// difference, error subtract, stride add and end compare are combinational. in_cmd.ready
// drops only when both buffer entries are full. The stride resets to one; the user writes
// it through cfg_wr only while the walker is idle, which the block does not enforce.
module ray_voxel_line_walker_3d import rvlw_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  rvlw_cmd_if.sink    in_cmd,
  rvlw_vox_if.source  out_vox,
  rvlw_cfg_if.sink    cfg_wr
);

  cmd_t cmd;
  vox_t res_data;
  vox_t buf_data;
  logic res_valid;
  logic in_fire;
  logic space;

  // Pack the command beat
  always_comb begin
    cmd.command = in_cmd.command;
    cmd.start_x = in_cmd.start_x;
    cmd.start_y = in_cmd.start_y;
    cmd.start_z = in_cmd.start_z;
    cmd.end_x   = in_cmd.end_x;
    cmd.end_y   = in_cmd.end_y;
    cmd.end_z   = in_cmd.end_z;
  end

  assign in_cmd.ready = space;
  assign in_fire      = in_cmd.valid && space;
  assign cfg_wr.ready = 1'b1;

  rvlw_walk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_cmd    (cmd),
    .cfg_fire  (cfg_wr.valid),
    .cfg_data  (cfg_wr.data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  rvlw_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .space     (space),
    .out_valid (out_vox.valid),
    .out_ready (out_vox.ready),
    .out_data  (buf_data)
  );

  // Unpack the result beat
  assign out_vox.voxel_x     = buf_data.voxel_x;
  assign out_vox.voxel_y     = buf_data.voxel_y;
  assign out_vox.voxel_z     = buf_data.voxel_z;
  assign out_vox.point_valid = buf_data.point_valid;
  assign out_vox.final_point = buf_data.final_point;

endmodule

FILE: design/rvlw_walk_core.sv
// Walker core: ray set-up on begin and one Bresenham step per advance.
module rvlw_walk_core import rvlw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  cmd_t in_cmd,
  input  logic cfg_fire,
  input  step_t cfg_data,
  output logic res_valid,
  output vox_t res_data
);

  step_t  step_size_r;
  coord_t cursor_x_r, cursor_y_r, cursor_z_r;
  coord_t target_major_r;
  coord_t delta_major_r, delta_minor_a_r, delta_minor_b_r;
  err_t   error_a_r, error_b_r;
  logic [2:0] step_signs_r;
  logic [1:0] swap_flags_r;
  logic   ray_active_r;

  coord_t cursor_x_nxt, cursor_y_nxt, cursor_z_nxt;
  coord_t target_major_nxt;
  coord_t delta_major_nxt, delta_minor_a_nxt, delta_minor_b_nxt;
  err_t   error_a_nxt, error_b_nxt;
  logic [2:0] step_signs_nxt;
  logic [1:0] swap_flags_nxt;
  logic   ray_active_nxt;

  // Set-up signals
  coord_t adx, ady, adz, adx1, ady1;
  coord_t sx1, sy1, ex1, ey1;
  coord_t sx2, sz2, ex2, ez2;
  logic   swap_xy, swap_xz;

  // Step signals
  coord_t px, py, pz, pxa, pza;
  err_t   ea_sub, eb_sub;
  coord_t cx_step;
  logic   done_now;

  // Set up a new ray: pick the driving axis and fix deltas and signs
  always_comb begin
    adx     = absdiff(in_cmd.end_x, in_cmd.start_x);
    ady     = absdiff(in_cmd.end_y, in_cmd.start_y);
    adz     = absdiff(in_cmd.end_z, in_cmd.start_z);
    swap_xy = ady > adx;
    sx1     = swap_xy ? in_cmd.start_y : in_cmd.start_x;
    sy1     = swap_xy ? in_cmd.start_x : in_cmd.start_y;
    ex1     = swap_xy ? in_cmd.end_y   : in_cmd.end_x;
    ey1     = swap_xy ? in_cmd.end_x   : in_cmd.end_y;
    adx1    = swap_xy ? ady : adx;
    ady1    = swap_xy ? adx : ady;
    swap_xz = adz > adx1;
    sx2     = swap_xz ? in_cmd.start_z : sx1;
    sz2     = swap_xz ? sx1 : in_cmd.start_z;
    ex2     = swap_xz ? in_cmd.end_z : ex1;
    ez2     = swap_xz ? ex1 : in_cmd.end_z;
  end

  // Advance: emit the current point, then step errors and cursor
  always_comb begin
    done_now = walk_done(cursor_x_r, target_major_r, step_size_r);
    pxa      = swap_flags_r[1] ? cursor_z_r : cursor_x_r;
    pza      = swap_flags_r[1] ? cursor_x_r : cursor_z_r;
    px       = swap_flags_r[0] ? cursor_y_r : pxa;
    py       = swap_flags_r[0] ? pxa : cursor_y_r;
    pz       = pza;
    ea_sub   = error_a_r - err_t'(delta_minor_a_r);
    eb_sub   = error_b_r - err_t'(delta_minor_b_r);
    cx_step  = step_add(cursor_x_r, step_signs_r[0], step_size_r);
  end

  // Next state and result
  always_comb begin
    cursor_x_nxt      = cursor_x_r;
    cursor_y_nxt      = cursor_y_r;
    cursor_z_nxt      = cursor_z_r;
    target_major_nxt  = target_major_r;
    delta_major_nxt   = delta_major_r;
    delta_minor_a_nxt = delta_minor_a_r;
    delta_minor_b_nxt = delta_minor_b_r;
    error_a_nxt       = error_a_r;
    error_b_nxt       = error_b_r;
    step_signs_nxt    = step_signs_r;
    swap_flags_nxt    = swap_flags_r;
    ray_active_nxt    = ray_active_r;
    res_valid         = 1'b0;
    res_data          = '0;
    if (in_fire) begin
      case (in_cmd.command)
        CMD_BEGIN: begin
          swap_flags_nxt    = {swap_xz, swap_xy};
          delta_major_nxt   = swap_xz ? adz : adx1;
          delta_minor_a_nxt = ady1;
          delta_minor_b_nxt = swap_xz ? adx1 : adz;
          error_a_nxt       = err_t'(delta_major_nxt >> 1);
          error_b_nxt       = err_t'(delta_major_nxt >> 1);
          step_signs_nxt    = {!(sz2 < ez2), !(sy1 < ey1), !(sx2 < ex2)};
          cursor_x_nxt      = sx2;
          cursor_y_nxt      = sy1;
          cursor_z_nxt      = sz2;
          target_major_nxt  = ex2;
          ray_active_nxt    = 1'b1;
        end
        CMD_ADVANCE: begin
          res_valid = 1'b1;
          if (!ray_active_r || done_now) begin
            ray_active_nxt = 1'b0;
          end else begin
            error_a_nxt = ea_sub;
            error_b_nxt = eb_sub;
            if (ea_sub < 0) begin
              cursor_y_nxt = step_add(cursor_y_r, step_signs_r[1], step_size_r);
              error_a_nxt  = ea_sub + err_t'(delta_major_r);
            end
            if (eb_sub < 0) begin
              cursor_z_nxt = step_add(cursor_z_r, step_signs_r[2], step_size_r);
              error_b_nxt  = eb_sub + err_t'(delta_major_r);
            end
            cursor_x_nxt         = cx_step;
            res_data.voxel_x     = px;
            res_data.voxel_y     = py;
            res_data.voxel_z     = pz;
            res_data.point_valid = 1'b1;
            res_data.final_point = walk_done(cx_step, target_major_r, step_size_r);
            ray_active_nxt       = !res_data.final_point;
          end
        end
        default: begin
          ray_active_nxt = ray_active_r;
        end
      endcase
    end
  end

  // Hold walk state and the stride register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r     <= STEP_RESET;
      cursor_x_r      <= '0;
      cursor_y_r      <= '0;
      cursor_z_r      <= '0;
      target_major_r  <= '0;
      delta_major_r   <= '0;
      delta_minor_a_r <= '0;
      delta_minor_b_r <= '0;
      error_a_r       <= '0;
      error_b_r       <= '0;
      step_signs_r    <= '0;
      swap_flags_r    <= '0;
      ray_active_r    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        step_size_r <= cfg_data;
      end
      cursor_x_r      <= cursor_x_nxt;
      cursor_y_r      <= cursor_y_nxt;
      cursor_z_r      <= cursor_z_nxt;
      target_major_r  <= target_major_nxt;
      delta_major_r   <= delta_major_nxt;
      delta_minor_a_r <= delta_minor_a_nxt;
      delta_minor_b_r <= delta_minor_b_nxt;
      error_a_r       <= error_a_nxt;
      error_b_r       <= error_b_nxt;
      step_signs_r    <= step_signs_nxt;
      swap_flags_r    <= swap_flags_nxt;
      ray_active_r    <= ray_active_nxt;
    end
  end

  // Error terms stay within [0, delta_major]
  a_err_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    !error_a_r[ERR_BITS-1] && (error_a_r <= err_t'(delta_major_r)))
    else $error("error_a out of range");

  a_err_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    !error_b_r[ERR_BITS-1] && (error_b_r <= err_t'(delta_major_r)))
    else $error("error_b out of range");

  // Major axis is never shorter than a minor one
  a_major_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (delta_minor_a_r <= delta_major_r) && (delta_minor_b_r <= delta_major_r))
    else $error("major delta smaller than a minor delta");

  // A begin always leaves a ray loaded
  a_begin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd.command == CMD_BEGIN) |=> ray_active_r)
    else $error("begin did not load a ray");

  // A final point ends the ray
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_data.final_point) |=> !ray_active_r)
    else $error("ray still active after final point");

endmodule

FILE: design/rvlw_out_buf.sv
// Two-entry result buffer: output register with a skid stage behind it.
module rvlw_out_buf import rvlw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  vox_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output vox_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  vox_t out_data_r, out_data_nxt;
  vox_t skid_data_r, skid_data_nxt;
  logic pop;

  assign pop       = out_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Advance the queue: refill the head from skid, park a new beat behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // Skid only fills behind a waiting head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat with empty head");

  // No push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_valid_r && !pop))
    else $error("push into full result buffer");

  // Draining the last beat empties the buffer
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && !skid_valid_r) |=> !out_valid_r)
    else $error("buffer not empty after last beat taken");

endmodule
